// File: rtl/crc_checked_command_frame_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef CRC_CHECKED_COMMAND_FRAME_CLASSIFIER_DEFINES_SVH
`define CRC_CHECKED_COMMAND_FRAME_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

// File: rtl/ccfc_pkg.sv
package ccfc_pkg;

    localparam int MAX_TRANSFER = 512;
    localparam int LEN_W = 10;
    localparam int POS_CLOG = $clog2(MAX_TRANSFER + 1);
    localparam int POS_W = (POS_CLOG > LEN_W) ? POS_CLOG : LEN_W;

    localparam int FRAME_LEN = 138;
    localparam int PAYLOAD_AT = 8;
    localparam int PAYLOAD_LEN = 128;
    localparam logic [7:0] HDR_BYTE_A = 8'h80;
    localparam logic [7:0] HDR_BYTE_B = 8'h01;
    localparam logic [7:0] BLOCK_MAGIC = 8'h81;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Command strings as ASCII codes, first character in the top byte.
    localparam int RESCUE_LEN = 12;
    localparam int ENTER_LEN = 21;
    localparam int EXIT_LEN = 20;
    localparam logic [8*RESCUE_LEN-1:0] RESCUE_STR = 96'h656e7465725f726573637565;
    localparam logic [8*ENTER_LEN-1:0] ENTER_STR =
        168'h656e7465725f757067726164655f6578745f6d6375;
    localparam logic [8*EXIT_LEN-1:0] EXIT_STR =
        160'h657869745f757067726164655f6578745f6d6375;

    typedef enum logic [2:0] {
        VERDICT_DATA    = 3'd0,
        VERDICT_RESCUE  = 3'd1,
        VERDICT_ENTER   = 3'd2,
        VERDICT_EXIT    = 3'd3,
        VERDICT_BLOCK   = 3'd4,
        VERDICT_UNKNOWN = 3'd5,
        VERDICT_ERROR   = 3'd6
    } verdict_t;

    localparam logic [1:0] CFG_CONTROL_LEAD = 2'd0;
    localparam logic [1:0] CFG_UPGRADE_LEAD = 2'd1;
    localparam logic [1:0] CFG_UPGRADE_EN   = 2'd2;

    typedef struct packed {
        logic [7:0] control_lead;
        logic [7:0] upgrade_lead;
        logic       upgrade_en;
    } cfg_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [LEN_W-1:0] length;
        logic             overflow;
    } result_t;

    // One byte of CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] rescue_char(logic [3:0] k);
        logic [7:0] ch;
        ch = '0;
        if (int'(k) < RESCUE_LEN)
        begin
            ch = RESCUE_STR[8*(RESCUE_LEN-1-int'(k)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] enter_char(logic [4:0] k);
        logic [7:0] ch;
        ch = '0;
        if (int'(k) < ENTER_LEN)
        begin
            ch = ENTER_STR[8*(ENTER_LEN-1-int'(k)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] exit_char(logic [4:0] k);
        logic [7:0] ch;
        ch = '0;
        if (int'(k) < EXIT_LEN)
        begin
            ch = EXIT_STR[8*(EXIT_LEN-1-int'(k)) +: 8];
        end
        return ch;
    endfunction

endpackage

// File: rtl/ccfc_track.sv
`include "crc_checked_command_frame_classifier_defines.svh"

module ccfc_track (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             transfer_error,
    input  ccfc_pkg::cfg_t   cfg,
    output ccfc_pkg::result_t result
);
    import ccfc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic             hdr_reg, hdr_next;
    logic             uhdr_reg, uhdr_next;
    logic [7:0]       trl_reg, trl_next;
    logic             rescue_reg, rescue_next;
    logic             enter_reg, enter_next;
    logic             exit_reg, exit_next;
    logic             ovf_reg, ovf_next;
    logic [POS_W-1:0] pos_off;
    logic             frame;

    assign pos_off = pos_reg - POS_W'(PAYLOAD_AT);

    // Per-byte update of the transfer state.
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        hdr_next    = hdr_reg;
        uhdr_next   = uhdr_reg;
        trl_next    = trl_reg;
        rescue_next = rescue_reg;
        enter_next  = enter_reg;
        exit_next   = exit_reg;
        ovf_next    = ovf_reg;
        if (pos_reg >= POS_W'(MAX_TRANSFER))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == '0)
            begin
                hdr_next  = hdr_reg && (data_byte == cfg.control_lead);
                uhdr_next = uhdr_reg && (data_byte == cfg.upgrade_lead);
            end
            else if (pos_reg == POS_W'(1))
            begin
                hdr_next  = hdr_reg && (data_byte == HDR_BYTE_A);
                uhdr_next = uhdr_reg && (data_byte == BLOCK_MAGIC);
            end
            else if (pos_reg == POS_W'(2))
            begin
                hdr_next = hdr_reg && (data_byte == HDR_BYTE_B);
            end
            if (pos_reg >= POS_W'(PAYLOAD_AT) &&
                pos_reg < POS_W'(PAYLOAD_AT + PAYLOAD_LEN))
            begin
                crc_next = crc16_byte(crc_reg, data_byte);
                if (pos_off < POS_W'(RESCUE_LEN))
                begin
                    rescue_next = rescue_reg && (data_byte == rescue_char(pos_off[3:0]));
                end
                if (pos_off < POS_W'(ENTER_LEN))
                begin
                    enter_next = enter_reg && (data_byte == enter_char(pos_off[4:0]));
                end
                if (pos_off < POS_W'(EXIT_LEN))
                begin
                    exit_next = exit_reg && (data_byte == exit_char(pos_off[4:0]));
                end
            end
            else if (pos_reg == POS_W'(PAYLOAD_AT + PAYLOAD_LEN))
            begin
                trl_next = data_byte;
            end
        end
    end

    // Verdict for the transfer, meaningful on its last byte.
    assign frame = !ovf_next && (pos_next == POS_W'(FRAME_LEN)) && hdr_next &&
                   ({trl_next, data_byte} == crc_next);

    always_comb
    begin
        result.length   = pos_next[LEN_W-1:0];
        result.overflow = ovf_next;
        if (transfer_error)
        begin
            result.verdict = VERDICT_ERROR;
        end
        else if (frame)
        begin
            if (rescue_next)
                result.verdict = VERDICT_RESCUE;
            else if (cfg.upgrade_en && enter_next)
                result.verdict = VERDICT_ENTER;
            else if (cfg.upgrade_en && exit_next)
                result.verdict = VERDICT_EXIT;
            else
                result.verdict = VERDICT_UNKNOWN;
        end
        else if (cfg.upgrade_en && uhdr_next && pos_next >= POS_W'(2))
        begin
            result.verdict = VERDICT_BLOCK;
        end
        else
        begin
            result.verdict = VERDICT_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            crc_reg    <= '0;
            hdr_reg    <= 1'b1;
            uhdr_reg   <= 1'b1;
            trl_reg    <= '0;
            rescue_reg <= 1'b1;
            enter_reg  <= 1'b1;
            exit_reg   <= 1'b1;
            ovf_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                crc_reg    <= '0;
                hdr_reg    <= 1'b1;
                uhdr_reg   <= 1'b1;
                trl_reg    <= '0;
                rescue_reg <= 1'b1;
                enter_reg  <= 1'b1;
                exit_reg   <= 1'b1;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                hdr_reg    <= hdr_next;
                uhdr_reg   <= uhdr_next;
                trl_reg    <= trl_next;
                rescue_reg <= rescue_next;
                enter_reg  <= enter_next;
                exit_reg   <= exit_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

    `ASSERT_NEVER(a_pos_bounded, pos_reg > POS_W'(MAX_TRANSFER), "byte position past maximum")
    `ASSERT_CLK(a_ovf_saturated, ovf_reg |-> pos_reg == POS_W'(MAX_TRANSFER), "overflow before saturation")
    `ASSERT_CLK(a_clear_after_last, step && last_byte |=> pos_reg == '0 && !ovf_reg, "state not cleared after last byte")

endmodule

// File: rtl/crc_checked_command_frame_classifier.sv
// Byte-serial classifier for received transfers.
// Input channel: one word per byte (data_byte, last_byte, transfer_error), moved on
// a rising edge with byte_valid high and byte_stall low. transfer_error is only
// looked at together with last_byte.
// Output channel: one word per transfer (verdict, transfer_length, length_overflow),
// produced for the last byte only, moved with result_valid high and result_stall low.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the control
// lead byte, the upgrade lead byte or the upgrade enable; cfg_ready is always high.
// Path: a byte is registered in the input register on acceptance and processed
// from there; a last byte's result is then registered in the result register,
// which raises result_valid.
// Throughput: one byte per cycle but for a stalled last byte, set by the state
// update (byte-wide CRC-16 step, header/command compares) behind the input register.
// Stall: while a result waits under result_stall, non-final bytes keep flowing;
// a following last byte waits in the input register with byte_stall high until
// the waiting word is taken.
// Reset: clears valids, configuration to its defaults (control lead 0, upgrade lead
// 2, upgrades disabled) and all per-transfer state; no clearing pass is needed.
`include "crc_checked_command_frame_classifier_defines.svh"

module crc_checked_command_frame_classifier (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    input  logic                       transfer_error,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [2:0]                 verdict,
    output logic [ccfc_pkg::LEN_W-1:0] transfer_length,
    output logic                       length_overflow,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data
);
    import ccfc_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_err_reg;

    // Result register.
    logic    out_valid_reg;
    result_t out_reg;

    result_t step_result;
    logic    accept;
    logic    advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_lead <= 8'd0;
            cfg_reg.upgrade_lead <= 8'd2;
            cfg_reg.upgrade_en   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CONTROL_LEAD: cfg_reg.control_lead <= cfg_data;
                CFG_UPGRADE_LEAD: cfg_reg.upgrade_lead <= cfg_data;
                CFG_UPGRADE_EN:   cfg_reg.upgrade_en   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // A registered byte moves on unless it is a last byte and the result
    // register is still held by the receiver.
    assign advance    = in_valid_reg && !(in_last_reg && out_valid_reg && result_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
            in_err_reg  <= transfer_error;
        end
    end

    ccfc_track u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .data_byte      (in_byte_reg),
        .last_byte      (in_last_reg),
        .transfer_error (in_err_reg),
        .cfg            (cfg_reg),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_reg <= step_result;
        end
    end

    assign result_valid    = out_valid_reg;
    assign verdict         = out_reg.verdict;
    assign transfer_length = out_reg.length;
    assign length_overflow = out_reg.overflow;

    `ASSERT_CLK(a_result_from_last, $rose(result_valid) |-> $past(advance && in_last_reg), "result without a last byte")
    `ASSERT_CLK(a_stall_holds_input, byte_stall |=> in_valid_reg, "stalled input register emptied")
    `ASSERT_CLK(a_ovf_length, result_valid && length_overflow |-> transfer_length == LEN_W'(MAX_TRANSFER), "overflow without saturated length")

endmodule
